// ===== design/deq_pkg.sv =====
// Shared types, request and status codes for the double-ended queue.
package deq_pkg;

    localparam int DATA_W     = 32;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int DEPTH_DEFLT = 1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SIZE       = 3'd4,
        REQ_EMPTY      = 3'd5,
        REQ_FRONT      = 3'd6,
        REQ_BACK       = 3'd7
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch a new request
        logic write;       // store the word, advance pointers
        logic read;        // read the addressed slot, pop if asked
        logic emit_full;   // result: push dropped
        logic emit_empty;  // result: nothing to pop or peek
        logic emit_info;   // result: size or empty query
        logic emit_word;   // result: word read last cycle
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic empty;
        logic full;
    } t_stat;

endpackage

// ===== design/deq_dp.sv =====
// Datapath: ring buffer memory, head and count registers, result registers.
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  deq_pkg::t_cmd                 i_cmd,
    output deq_pkg::t_stat                o_stat,
    input  logic [deq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [deq_pkg::DATA_W-1:0]    i_value,
    output logic                          o_valid,
    output logic [deq_pkg::DATA_W-1:0]    o_data,
    output logic [deq_pkg::STATUS_W-1:0]  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S  = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [deq_pkg::DATA_W-1:0] r_mem [DEPTH];

    deq_pkg::t_req              r_req;
    logic [deq_pkg::DATA_W-1:0] r_value;
    logic [AW-1:0]              r_head;
    logic [CW-1:0]              r_count;
    logic [deq_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_valid;
    logic [deq_pkg::DATA_W-1:0] r_data;
    deq_pkg::t_status           r_status;

    logic                       w_empty;
    logic                       w_full;
    logic [AW-1:0]              w_head_prev;
    logic [AW-1:0]              w_head_next;
    logic [CW-1:0]              w_count_dec;
    logic [AW-1:0]              w_back_off;
    logic [AW:0]                w_back_sum;
    logic [AW-1:0]              w_back_slot;
    logic [AW-1:0]              w_addr;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == DEPTH_C);
    assign w_head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign w_head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_count_dec = r_count - 1'b1;

    // back slot: count for a back push (not full), count-1 for pop/peek back
    assign w_back_off  = (r_req == deq_pkg::REQ_PUSH_BACK) ? r_count[AW-1:0]
                                                           : w_count_dec[AW-1:0];
    assign w_back_sum  = {1'b0, r_head} + {1'b0, w_back_off};

    always_comb begin
        if (w_back_sum >= DEPTH_S) begin
            w_back_slot = AW'(w_back_sum - DEPTH_S);
        end else begin
            w_back_slot = w_back_sum[AW-1:0];
        end
    end

    always_comb begin
        case (r_req)
            deq_pkg::REQ_PUSH_FRONT: w_addr = w_head_prev;
            deq_pkg::REQ_POP_FRONT,
            deq_pkg::REQ_FRONT:      w_addr = r_head;
            default:                 w_addr = w_back_slot;
        endcase
    end

    assign o_stat.req   = r_req;
    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= deq_pkg::t_req'(i_req_type);
            r_value <= i_value;
        end
    end

    // storage, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[w_addr] <= r_value;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.write) begin
            r_count <= r_count + 1'b1;
            if (r_req == deq_pkg::REQ_PUSH_FRONT) begin
                r_head <= w_head_prev;
            end
        end else if (i_cmd.read) begin
            if (r_req == deq_pkg::REQ_POP_FRONT) begin
                r_head  <= w_head_next;
                r_count <= w_count_dec;
            end else if (r_req == deq_pkg::REQ_POP_BACK) begin
                r_count <= w_count_dec;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_full | i_cmd.emit_empty | i_cmd.emit_info
                     | i_cmd.emit_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_full) begin
            r_data   <= '0;
            r_status <= deq_pkg::ST_FULL;
        end else if (i_cmd.emit_empty) begin
            r_data   <= '0;
            r_status <= deq_pkg::ST_EMPTY;
        end else if (i_cmd.emit_info) begin
            r_status <= deq_pkg::ST_OK;
            if (r_req == deq_pkg::REQ_SIZE) begin
                r_data <= deq_pkg::DATA_W'(r_count);
            end else begin
                r_data <= deq_pkg::DATA_W'(w_empty);
            end
        end else if (i_cmd.emit_word) begin
            r_data   <= r_rd_data;
            r_status <= deq_pkg::ST_OK;
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;

endmodule

// ===== design/deq_ctrl.sv =====
// Controller: request sequencing state machine for the double-ended queue.
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  deq_pkg::t_stat i_stat,
    output deq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                    n_busy        = 1'b1;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
                case (i_stat.req)
                    deq_pkg::REQ_PUSH_FRONT,
                    deq_pkg::REQ_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.emit_full = 1'b1;
                        end else begin
                            o_cmd.write = 1'b1;
                        end
                    end
                    deq_pkg::REQ_SIZE,
                    deq_pkg::REQ_EMPTY: begin
                        o_cmd.emit_info = 1'b1;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_cmd.emit_empty = 1'b1;
                        end else begin
                            o_cmd.read = 1'b1;
                            n_state    = S_READ;
                            n_busy     = 1'b1;
                        end
                    end
                endcase
            end
            S_READ: begin
                o_cmd.emit_word = 1'b1;
                n_state         = S_IDLE;
                n_busy          = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

// ===== design/double_ended_queue.sv =====
// Top level: double-ended queue of 32-bit words on a circular buffer.
//
//  channel  | handshake              | ports
//  ---------+------------------------+-------------------------------
//  request  | start high, busy low   | i_req_type, i_value
//  result   | o_valid, one cycle     | o_data, o_status
//
// Sequence: after the accept edge busy stays high through the decode state, and
// also through the read state for a pop or peek that returns a word, a step set
// by the registered read of the single-port entry memory. The result strobe is
// registered from the decode state, or from the read state for a returned word.
// Reset: synchronous, active low; head and count clear to zero, memory
// contents are not cleared (only occupied entries are ever read).
// Stalls: the receiver cannot stall; each result is on o_data/o_status for
// exactly one cycle with o_valid high. busy holds off the next request.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [deq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [deq_pkg::DATA_W-1:0]    i_value,
    output logic                          o_valid,
    output logic [deq_pkg::DATA_W-1:0]    o_data,
    output logic [deq_pkg::STATUS_W-1:0]  o_status
);

    deq_pkg::t_cmd  w_cmd;
    deq_pkg::t_stat w_stat;

    // sequencing: accept, decode, optional memory read
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // storage, pointers and result registers
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .o_status   (o_status)
    );

endmodule
